[sv/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies expression in the next
`define ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[sv/nslp_pkg.sv]
// types, constants and helper functions of the numbered string line parser
// no dependencies; used by every module of the block
package nslp_pkg;

    localparam int unsigned ID_OUT_W    = 12;
    localparam int unsigned COUNT_W     = 13;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = QPTR_W + 1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    typedef enum logic [2:0] {
        MODE_WS,
        MODE_SIGN,
        MODE_ZERO,
        MODE_ZEROX,
        MODE_DIGITS,
        MODE_SEEK,
        MODE_STR,
        MODE_SKIP
    } mode_t;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } base_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    typedef struct packed {
        logic [7:0] chr;
        logic       chr_valid;
        logic       eos;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } pair_t;

    typedef struct packed {
        logic [ID_OUT_W-1:0] id;
        logic                two;
        result_t             first;
        result_t             second;
    } bundle_t;

    function automatic digit_t digit_value(input logic [7:0] c);
        digit_t d;
        d = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_ZERO);
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
        begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_LOWER_A + 8'd10);
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
        begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_UPPER_A + 8'd10);
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
               c == CH_VT || c == CH_FF;
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return c == CH_CR || c == CH_LF;
    endfunction

    function automatic pair_t put(input pair_t p, input logic [7:0] c, input logic v,
                                  input logic e);
        pair_t q;
        q = p;
        if (p.n == 2'd0)
        begin
            q.r0 = '{chr: c, chr_valid: v, eos: e};
            q.n  = 2'd1;
        end
        else if (p.n == 2'd1)
        begin
            q.r1 = '{chr: c, chr_valid: v, eos: e};
            q.n  = 2'd2;
        end
        return q;
    endfunction

    // flush a held backslash and mark the end of a kept string
    function automatic pair_t close_pair(input pair_t p, input logic held, input logic kept);
        pair_t q;
        q = p;
        if (held && kept)
            q = put(q, CH_BSLASH, 1'b1, 1'b0);
        if (kept)
        begin
            if (q.n == 2'd0)
                q = put(q, CH_NUL, 1'b0, 1'b1);
            else if (q.n == 2'd1)
                q.r0.eos = 1'b1;
            else
                q.r1.eos = 1'b1;
        end
        return q;
    endfunction

endpackage

[sv/nslp_queue.sv]
// short request queue between the parser front and the output back
// depends on nslp_pkg
module nslp_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  nslp_pkg::bundle_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output nslp_pkg::bundle_t head
);

    nslp_pkg::bundle_t                  entry_reg [nslp_pkg::QUEUE_DEPTH];
    logic [nslp_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [nslp_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [nslp_pkg::QCNT_W-1:0]        count_reg, count_next;

    assign full  = count_reg == nslp_pkg::QCNT_W'(nslp_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[sv/nslp_front.sv]
// parser front: takes one text byte per cycle unless the queue is full, tracks the line state
// and packs the resolved characters of that byte into one queue request; depends on nslp_pkg
module nslp_front
#(
    parameter int MAX_IDS = 4096
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           text_valid,
    input  logic [7:0]                     text_byte,
    input  logic                           is_last,
    input  logic [nslp_pkg::COUNT_W-1:0]   string_count,
    input  logic                           queue_full,
    output logic                           push,
    output nslp_pkg::bundle_t              push_data
);

    localparam int ID_W  = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
    localparam int V_W   = ID_W + 5;
    localparam int CMP_W = (ID_W > nslp_pkg::COUNT_W) ? ID_W : nslp_pkg::COUNT_W;
    localparam logic [V_W-1:0] MAX_V = V_W'(MAX_IDS);

    nslp_pkg::mode_t  mode_reg, mode_next;
    nslp_pkg::base_t  base_reg, base_next;
    logic [ID_W-1:0]  acc_reg, acc_next;
    logic             neg_reg, neg_next;
    logic             ovf_reg, ovf_next;
    logic             held_reg, held_next;
    logic             prevbs_reg, prevbs_next;
    logic             done_reg, done_next;
    logic             kept_reg, kept_next;

    logic                         accept;
    nslp_pkg::pair_t              pair;
    logic [ID_W-1:0]              id_mid;
    logic [ID_W+nslp_pkg::ID_OUT_W-1:0] id_wide;

    // returns {overflow, accumulator}
    function automatic logic [ID_W:0] add_digit(input logic [ID_W-1:0] a, input logic ov,
                                                input nslp_pkg::base_t b,
                                                input logic [3:0] d);
        logic [V_W-1:0] ax;
        logic [V_W-1:0] v;
        ax = V_W'(a);
        unique case (b)
            nslp_pkg::BASE_HEX: v = (ax << 4) + V_W'(d);
            nslp_pkg::BASE_OCT: v = (ax << 3) + V_W'(d);
            default:            v = (ax << 3) + (ax << 1) + V_W'(d);
        endcase
        if (ov || v >= MAX_V)
            return {1'b1, a};
        return {1'b0, v[ID_W-1:0]};
    endfunction

    function automatic logic kept_of(input logic [ID_W-1:0] a, input logic ov, input logic ng,
                                     input logic [nslp_pkg::COUNT_W-1:0] cnt);
        return !ov && !(ng && a != '0) && (CMP_W'(a) < CMP_W'(cnt));
    endfunction

    assign accept = text_valid && !queue_full;

    always_comb
    begin
        nslp_pkg::mode_t  m;
        nslp_pkg::base_t  b;
        logic [ID_W-1:0]  a;
        logic             ng, ov, hb, pb, dn, kp, fall, rad_ok;
        logic [7:0]       c;
        nslp_pkg::digit_t dg;
        nslp_pkg::pair_t  p;

        m  = mode_reg;
        b  = base_reg;
        a  = acc_reg;
        ng = neg_reg;
        ov = ovf_reg;
        hb = held_reg;
        pb = prevbs_reg;
        dn = done_reg;
        kp = kept_reg;
        c  = text_byte;
        dg = nslp_pkg::digit_value(c);
        p  = '0;
        fall = 1'b1;
        rad_ok = 1'b0;

        if (!dn)
        begin
            // number in progress
            unique case (m)
                nslp_pkg::MODE_ZERO:
                begin
                    if (c == nslp_pkg::CH_LOWER_X || c == nslp_pkg::CH_UPPER_X)
                    begin
                        m    = nslp_pkg::MODE_ZEROX;
                        fall = 1'b0;
                    end
                    else
                    begin
                        b = nslp_pkg::BASE_OCT;
                        if (dg.ok && dg.val < 4'd8)
                        begin
                            {ov, a} = add_digit(a, ov, b, dg.val);
                            m    = nslp_pkg::MODE_DIGITS;
                            fall = 1'b0;
                        end
                        else
                        begin
                            kp = kept_of(a, ov, ng, string_count);
                            m  = nslp_pkg::MODE_SEEK;
                        end
                    end
                end
                nslp_pkg::MODE_ZEROX:
                begin
                    if (dg.ok)
                    begin
                        b = nslp_pkg::BASE_HEX;
                        {ov, a} = add_digit(a, ov, b, dg.val);
                        m    = nslp_pkg::MODE_DIGITS;
                        fall = 1'b0;
                    end
                    else
                    begin
                        b  = nslp_pkg::BASE_OCT;
                        kp = kept_of(a, ov, ng, string_count);
                        m  = nslp_pkg::MODE_SEEK;
                    end
                end
                nslp_pkg::MODE_DIGITS:
                begin
                    unique case (b)
                        nslp_pkg::BASE_HEX: rad_ok = dg.ok;
                        nslp_pkg::BASE_OCT: rad_ok = dg.ok && dg.val < 4'd8;
                        default:            rad_ok = dg.ok && dg.val < 4'd10;
                    endcase
                    if (rad_ok)
                    begin
                        {ov, a} = add_digit(a, ov, b, dg.val);
                        fall = 1'b0;
                    end
                    else
                    begin
                        kp = kept_of(a, ov, ng, string_count);
                        m  = nslp_pkg::MODE_SEEK;
                    end
                end
                default:
                begin
                end
            endcase

            if (fall)
            begin
                unique case (m)
                    nslp_pkg::MODE_WS:
                    begin
                        if (c == nslp_pkg::CH_NUL)
                            dn = 1'b1;
                        else if (nslp_pkg::is_space(c))
                            m = nslp_pkg::MODE_WS;
                        else if (c == nslp_pkg::CH_PLUS || c == nslp_pkg::CH_MINUS)
                        begin
                            ng = c == nslp_pkg::CH_MINUS;
                            a  = '0;
                            ov = 1'b0;
                            b  = nslp_pkg::BASE_DEC;
                            m  = nslp_pkg::MODE_SIGN;
                        end
                        else if (c == nslp_pkg::CH_ZERO)
                        begin
                            ng = 1'b0;
                            a  = '0;
                            ov = 1'b0;
                            b  = nslp_pkg::BASE_DEC;
                            m  = nslp_pkg::MODE_ZERO;
                        end
                        else if (dg.ok && dg.val < 4'd10)
                        begin
                            ng = 1'b0;
                            a  = '0;
                            ov = 1'b0;
                            b  = nslp_pkg::BASE_DEC;
                            {ov, a} = add_digit(a, ov, b, dg.val);
                            m  = nslp_pkg::MODE_DIGITS;
                        end
                        else
                            m = nslp_pkg::MODE_SKIP;
                    end
                    nslp_pkg::MODE_SIGN:
                    begin
                        if (c == nslp_pkg::CH_NUL)
                        begin
                            dn = 1'b1;
                            m  = nslp_pkg::MODE_WS;
                        end
                        else if (c == nslp_pkg::CH_ZERO)
                            m = nslp_pkg::MODE_ZERO;
                        else if (dg.ok && dg.val < 4'd10)
                        begin
                            {ov, a} = add_digit(a, ov, b, dg.val);
                            m = nslp_pkg::MODE_DIGITS;
                        end
                        else if (nslp_pkg::is_eol(c))
                            m = nslp_pkg::MODE_WS;
                        else
                            m = nslp_pkg::MODE_SKIP;
                    end
                    nslp_pkg::MODE_SEEK:
                    begin
                        if (c == nslp_pkg::CH_NUL || nslp_pkg::is_eol(c))
                        begin
                            p  = nslp_pkg::close_pair(p, hb, kp);
                            hb = 1'b0;
                            kp = 1'b0;
                            pb = 1'b0;
                            dn = dn || c == nslp_pkg::CH_NUL;
                            m  = nslp_pkg::MODE_WS;
                        end
                        else if (c == nslp_pkg::CH_QUOTE)
                        begin
                            hb = 1'b0;
                            pb = 1'b0;
                            m  = nslp_pkg::MODE_STR;
                        end
                    end
                    nslp_pkg::MODE_STR:
                    begin
                        if (c == nslp_pkg::CH_NUL || nslp_pkg::is_eol(c) ||
                            (c == nslp_pkg::CH_QUOTE && !pb))
                        begin
                            p  = nslp_pkg::close_pair(p, hb, kp);
                            hb = 1'b0;
                            kp = 1'b0;
                            dn = dn || c == nslp_pkg::CH_NUL;
                            m  = (c == nslp_pkg::CH_QUOTE) ? nslp_pkg::MODE_SKIP
                                                           : nslp_pkg::MODE_WS;
                            pb = 1'b0;
                        end
                        else
                        begin
                            if (hb)
                            begin
                                hb = 1'b0;
                                if (c == nslp_pkg::CH_QUOTE || c == nslp_pkg::CH_BSLASH)
                                begin
                                    if (kp)
                                        p = nslp_pkg::put(p, c, 1'b1, 1'b0);
                                end
                                else if (c == nslp_pkg::CH_LOWER_N)
                                begin
                                    if (kp)
                                        p = nslp_pkg::put(p, nslp_pkg::CH_LF, 1'b1, 1'b0);
                                end
                                else if (kp)
                                begin
                                    p = nslp_pkg::put(p, nslp_pkg::CH_BSLASH, 1'b1, 1'b0);
                                    p = nslp_pkg::put(p, c, 1'b1, 1'b0);
                                end
                            end
                            else if (c == nslp_pkg::CH_BSLASH)
                                hb = 1'b1;
                            else if (kp)
                                p = nslp_pkg::put(p, c, 1'b1, 1'b0);
                            pb = c == nslp_pkg::CH_BSLASH;
                        end
                    end
                    default:
                    begin
                        if (c == nslp_pkg::CH_NUL)
                        begin
                            dn = 1'b1;
                            m  = nslp_pkg::MODE_WS;
                        end
                        else if (nslp_pkg::is_eol(c))
                            m = nslp_pkg::MODE_WS;
                    end
                endcase
            end
        end

        // end of buffer closes whatever is open
        if (is_last && !dn)
        begin
            if (m == nslp_pkg::MODE_ZERO || m == nslp_pkg::MODE_ZEROX ||
                m == nslp_pkg::MODE_DIGITS)
            begin
                if (m != nslp_pkg::MODE_DIGITS)
                    b = nslp_pkg::BASE_OCT;
                kp = kept_of(a, ov, ng, string_count);
                m  = nslp_pkg::MODE_SEEK;
            end
            if (m == nslp_pkg::MODE_SEEK || m == nslp_pkg::MODE_STR)
                p = nslp_pkg::close_pair(p, hb, kp);
        end

        id_mid = a;
        pair   = p;

        if (is_last)
        begin
            m  = nslp_pkg::MODE_WS;
            b  = nslp_pkg::BASE_DEC;
            a  = '0;
            ng = 1'b0;
            ov = 1'b0;
            hb = 1'b0;
            pb = 1'b0;
            dn = 1'b0;
            kp = 1'b0;
        end

        mode_next   = m;
        base_next   = b;
        acc_next    = a;
        neg_next    = ng;
        ovf_next    = ov;
        held_next   = hb;
        prevbs_next = pb;
        done_next   = dn;
        kept_next   = kp;
    end

    assign id_wide = {{nslp_pkg::ID_OUT_W{1'b0}}, id_mid};
    assign push    = accept && pair.n != 2'd0;

    always_comb
    begin
        push_data.id     = id_wide[nslp_pkg::ID_OUT_W-1:0];
        push_data.two    = pair.n[1];
        push_data.first  = pair.r0;
        push_data.second = pair.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= nslp_pkg::MODE_WS;
            base_reg   <= nslp_pkg::BASE_DEC;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
            held_reg   <= 1'b0;
            prevbs_reg <= 1'b0;
            done_reg   <= 1'b0;
            kept_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            base_reg   <= base_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            ovf_reg    <= ovf_next;
            held_reg   <= held_next;
            prevbs_reg <= prevbs_next;
            done_reg   <= done_next;
            kept_reg   <= kept_next;
        end
    end

endmodule

[sv/nslp_back.sv]
// output back: unpacks queue requests into single result items
// behind an output register; depends on nslp_pkg
module nslp_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            queue_empty,
    input  nslp_pkg::bundle_t               head,
    output logic                            pop,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [nslp_pkg::ID_OUT_W-1:0]   string_id,
    output logic [7:0]                      char_out,
    output logic                            char_valid,
    output logic                            end_of_string
);

    logic                          valid_reg, valid_next;
    logic                          sel_reg, sel_next;
    logic [nslp_pkg::ID_OUT_W-1:0] id_reg;
    nslp_pkg::result_t             item_reg;
    nslp_pkg::result_t             item;
    logic                          load;

    assign load = !queue_empty && (!valid_reg || !result_stall);
    assign item = sel_reg ? head.second : head.first;
    assign pop  = load && (sel_reg || !head.two);

    always_comb
    begin
        sel_next   = load ? (!sel_reg && head.two) : sel_reg;
        valid_next = load || (valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            id_reg   <= head.id;
            item_reg <= item;
        end
    end

    assign result_valid  = valid_reg;
    assign string_id     = id_reg;
    assign char_out      = item_reg.chr;
    assign char_valid    = item_reg.chr_valid;
    assign end_of_string = item_reg.eos;

endmodule

[sv/numbered_string_line_parser_unit.sv]
// Numbered string line parser: takes one text byte per cycle and returns the resolved string
// characters of each "number then quoted string" line with a non-negative number below
// string_count and MAX_IDS, tagged with the number as string id. A byte is taken in every
// cycle while the four-entry request queue between the parser front and the output register
// of the output back has room. The output delivers one item per cycle while result_stall is
// low, so a byte that resolves to two characters (a kept backslash together with the
// character that follows it) takes two output items and the queue absorbs the difference.
// string_count takes effect for numbers that end after the write; cfg_ready is always high.
// depends on nslp_pkg, nslp_front, nslp_queue, nslp_back
module numbered_string_line_parser_unit
#(
    parameter int MAX_IDS = 4096
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            text_valid,
    output logic                            text_stall,
    input  logic [7:0]                      text_byte,
    input  logic                            is_last,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [nslp_pkg::ID_OUT_W-1:0]   string_id,
    output logic [7:0]                      char_out,
    output logic                            char_valid,
    output logic                            end_of_string,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nslp_pkg::COUNT_W-1:0]    string_count
);

    logic [nslp_pkg::COUNT_W-1:0] count_reg;
    logic                         q_full, q_empty, q_push, q_pop;
    nslp_pkg::bundle_t            q_in, q_head;

    assign cfg_ready  = 1'b1;
    assign text_stall = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_valid && cfg_ready)
            count_reg <= string_count;
    end

    nslp_front #(
        .MAX_IDS (MAX_IDS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_byte    (text_byte),
        .is_last      (is_last),
        .string_count (count_reg),
        .queue_full   (q_full),
        .push         (q_push),
        .push_data    (q_in)
    );

    nslp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    nslp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (q_empty),
        .head          (q_head),
        .pop           (q_pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .string_id     (string_id),
        .char_out      (char_out),
        .char_valid    (char_valid),
        .end_of_string (end_of_string)
    );

endmodule

[sv/nslp_checker.sv]
// port-level checks of the numbered string line parser, bound to the top level
// depends on assert_macros.svh and nslp_pkg
`include "assert_macros.svh"

module nslp_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            result_valid,
    input logic                            result_stall,
    input logic [nslp_pkg::ID_OUT_W-1:0]   string_id,
    input logic [7:0]                      char_out,
    input logic                            char_valid,
    input logic                            end_of_string
);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, result_valid && result_stall,
        result_valid && $stable(string_id) && $stable(char_out) &&
        $stable(char_valid) && $stable(end_of_string),
        "stalled result changed")

    // a bare end item carries no character
    `ASSERT_CLK(a_bare_end, result_valid && !char_valid |-> end_of_string && char_out == 8'h00,
        "bare end item malformed")

    // characters of one string share its id
    `ASSERT_NEXT(a_same_id, result_valid && !result_stall && !end_of_string,
        !result_valid || string_id == $past(string_id),
        "string id changed inside a string")

endmodule

bind numbered_string_line_parser_unit nslp_checker u_nslp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .string_id     (string_id),
    .char_out      (char_out),
    .char_valid    (char_valid),
    .end_of_string (end_of_string)
);
